>>> design/c_lts_pkg.sv
// shared types, codes and character helpers of the token scanner
`default_nettype none
package c_lts_pkg;

  localparam int INDEX_BITS  = 20;
  localparam int LENGTH_BITS = 16;
  localparam int LEN_MAX_INT = (LENGTH_BITS > 16) ? 65535 : ((1 << LENGTH_BITS) - 1);
  localparam logic [20:0] LINE_MAX = 21'h1FFFFF;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam logic [4:0] KIND_EOF    = 5'd0;
  localparam logic [4:0] KIND_PLUS   = 5'd1;
  localparam logic [4:0] KIND_MINUS  = 5'd2;
  localparam logic [4:0] KIND_STAR   = 5'd3;
  localparam logic [4:0] KIND_SLASH  = 5'd4;
  localparam logic [4:0] KIND_LPAREN = 5'd5;
  localparam logic [4:0] KIND_RPAREN = 5'd6;
  localparam logic [4:0] KIND_LBRACE = 5'd7;
  localparam logic [4:0] KIND_RBRACE = 5'd8;
  localparam logic [4:0] KIND_COMMA  = 5'd9;
  localparam logic [4:0] KIND_SEMI   = 5'd10;
  localparam logic [4:0] KIND_ASSIGN = 5'd11;
  localparam logic [4:0] KIND_EQ     = 5'd12;
  localparam logic [4:0] KIND_NE     = 5'd13;
  localparam logic [4:0] KIND_GT     = 5'd14;
  localparam logic [4:0] KIND_GE     = 5'd15;
  localparam logic [4:0] KIND_LT     = 5'd16;
  localparam logic [4:0] KIND_LE     = 5'd17;
  localparam logic [4:0] KIND_NUMBER = 5'd18;
  localparam logic [4:0] KIND_IDENT  = 5'd19;
  localparam logic [4:0] KIND_IF     = 5'd20;
  localparam logic [4:0] KIND_ELSE   = 5'd21;
  localparam logic [4:0] KIND_WHILE  = 5'd22;
  localparam logic [4:0] KIND_FOR    = 5'd23;
  localparam logic [4:0] KIND_RETURN = 5'd24;
  localparam logic [4:0] KIND_ERROR  = 5'd25;

  localparam logic [47:0] KW_IF     = 48'h6966;
  localparam logic [47:0] KW_ELSE   = 48'h656C7365;
  localparam logic [47:0] KW_WHILE  = 48'h7768696C65;
  localparam logic [47:0] KW_FOR    = 48'h666F72;
  localparam logic [47:0] KW_RETURN = 48'h72657475726E;
  localparam logic [47:0] KW_INT    = 48'h696E74;

  typedef enum logic [2:0] {
    P_NONE  = 3'd0,
    P_NUM   = 3'd1,
    P_IDENT = 3'd2,
    P_EQ    = 3'd3,
    P_BANG  = 3'd4,
    P_GT    = 3'd5,
    P_LT    = 3'd6
  } pend_class_t;

  typedef struct packed {
    logic [15:0] col;
    logic [20:0] line;
    logic [15:0] len;
    logic [19:0] start;
    logic [4:0]  kind;
  } token_t;

  typedef struct packed {
    logic   has_two;
    token_t tok1;
    token_t tok0;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage
`default_nettype wire

>>> design/c_lts_front.sv
// front end: accepts bytes, tracks position, forms up to two tokens per item
`default_nettype none
module c_lts_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [7:0]          ch,
  input  wire logic                end_of_text,
  input  wire logic                q_full,
  output logic                     in_ready,
  output logic                     push,
  output c_lts_pkg::entry_t        push_entry
);

  localparam int IB = c_lts_pkg::INDEX_BITS;
  localparam int LB = c_lts_pkg::LENGTH_BITS;

  c_lts_pkg::pend_class_t pclass, pclass_next;
  logic [IB-1:0] pend_start, pend_start_next;
  logic [LB-1:0] pend_len, pend_len_next;
  logic [47:0]   prefix, prefix_next;
  logic [IB-1:0] byte_index, byte_index_next;
  logic [20:0]   line_count, line_count_next;
  logic [IB-1:0] line_start, line_start_next;
  logic [20:0]   pend_line, pend_line_next;
  logic [15:0]   pend_col, pend_col_next;

  c_lts_pkg::token_t flush_tok, cur_tok, pair_tok, a_tok, b_tok;
  logic flush_v, a_v, b_v, eof, ext, pair_v;
  logic [15:0] cur_col;
  logic accept;

  function automatic logic [15:0] col_of(input logic [IB-1:0] idx, input logic [IB-1:0] ls);
    logic [IB-1:0] diff;
    logic [32:0]   wide;
    diff = idx - ls;
    wide = 33'(diff) + 33'd1;
    return (wide > 33'd65535) ? 16'hFFFF : wide[15:0];
  endfunction

  function automatic logic [4:0] ident_kind(input logic [LB-1:0] len, input logic [47:0] p);
    logic [4:0] k;
    k = c_lts_pkg::KIND_IDENT;
    if (len == LB'(2) && p == c_lts_pkg::KW_IF) k = c_lts_pkg::KIND_IF;
    if (len == LB'(4) && p == c_lts_pkg::KW_ELSE) k = c_lts_pkg::KIND_ELSE;
    if (len == LB'(5) && p == c_lts_pkg::KW_WHILE) k = c_lts_pkg::KIND_WHILE;
    if (len == LB'(3) && p == c_lts_pkg::KW_FOR) k = c_lts_pkg::KIND_FOR;
    if (len == LB'(6) && p == c_lts_pkg::KW_RETURN) k = c_lts_pkg::KIND_RETURN;
    return k;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign eof      = end_of_text || (ch == 8'h00);
  assign cur_col  = col_of(byte_index, line_start);

  // token that the pending class gives when it is cut off
  always_comb begin
    flush_v         = 1'b1;
    flush_tok.start = 20'(pend_start);
    flush_tok.line  = pend_line;
    flush_tok.col   = pend_col;
    flush_tok.len   = 16'd1;
    flush_tok.kind  = c_lts_pkg::KIND_ERROR;
    unique case (pclass)
      c_lts_pkg::P_NUM: begin
        flush_tok.kind = c_lts_pkg::KIND_NUMBER;
        flush_tok.len  = 16'(pend_len);
      end
      c_lts_pkg::P_IDENT: begin
        if (pend_len == LB'(3) && prefix == c_lts_pkg::KW_INT) begin
          flush_tok.kind = c_lts_pkg::KIND_NUMBER;
          flush_tok.len  = 16'd0;
        end else begin
          flush_tok.kind = ident_kind(pend_len, prefix);
          flush_tok.len  = 16'(pend_len);
        end
      end
      c_lts_pkg::P_EQ:   flush_tok.kind = c_lts_pkg::KIND_ASSIGN;
      c_lts_pkg::P_BANG: flush_tok.kind = c_lts_pkg::KIND_ERROR;
      c_lts_pkg::P_GT:   flush_tok.kind = c_lts_pkg::KIND_GT;
      c_lts_pkg::P_LT:   flush_tok.kind = c_lts_pkg::KIND_LT;
      default:           flush_v = 1'b0;
    endcase
  end

  // two-character compare that closes a pending operator
  always_comb begin
    pair_v        = 1'b0;
    ext           = 1'b0;
    pair_tok      = flush_tok;
    pair_tok.len  = 16'd2;
    pair_tok.kind = c_lts_pkg::KIND_LE;
    unique case (pclass)
      c_lts_pkg::P_NUM:   ext = c_lts_pkg::is_digit(ch);
      c_lts_pkg::P_IDENT: ext = c_lts_pkg::is_digit(ch) || c_lts_pkg::is_letter(ch);
      c_lts_pkg::P_EQ: begin
        if (ch == "=") begin
          pair_v        = 1'b1;
          pair_tok.kind = c_lts_pkg::KIND_EQ;
        end else if (ch == "<") begin
          pair_v        = 1'b1;
          pair_tok.kind = c_lts_pkg::KIND_LE;
        end
      end
      c_lts_pkg::P_BANG: begin
        pair_v        = (ch == "=");
        pair_tok.kind = c_lts_pkg::KIND_NE;
      end
      c_lts_pkg::P_GT: begin
        pair_v        = (ch == "=");
        pair_tok.kind = c_lts_pkg::KIND_GE;
      end
      c_lts_pkg::P_LT: begin
        pair_v        = (ch == "=");
        pair_tok.kind = c_lts_pkg::KIND_LE;
      end
      default: ;
    endcase
  end

  always_comb begin
    pclass_next     = pclass;
    pend_start_next = pend_start;
    pend_len_next   = pend_len;
    prefix_next     = prefix;
    byte_index_next = byte_index;
    line_count_next = line_count;
    line_start_next = line_start;
    pend_line_next  = pend_line;
    pend_col_next   = pend_col;
    cur_tok.start   = 20'(byte_index);
    cur_tok.line    = line_count;
    cur_tok.col     = cur_col;
    cur_tok.len     = 16'd1;
    cur_tok.kind    = c_lts_pkg::KIND_ERROR;
    a_v             = 1'b0;
    a_tok           = flush_tok;
    b_v             = 1'b0;
    b_tok           = cur_tok;
    if (eof) begin
      a_v          = flush_v;
      b_v          = 1'b1;
      b_tok.kind   = c_lts_pkg::KIND_EOF;
      b_tok.len    = 16'd0;
      pclass_next  = c_lts_pkg::P_NONE;
      pend_len_next = '0;
      prefix_next  = '0;
    end else begin
      byte_index_next = byte_index + IB'(1);
      if (ext) begin
        if (pend_len < LB'(c_lts_pkg::LEN_MAX_INT)) pend_len_next = pend_len + LB'(1);
        if (pclass == c_lts_pkg::P_IDENT && pend_len < LB'(6)) prefix_next = {prefix[39:0], ch};
      end else if (pair_v) begin
        b_v           = 1'b1;
        b_tok         = pair_tok;
        pclass_next   = c_lts_pkg::P_NONE;
        pend_len_next = '0;
        prefix_next   = '0;
      end else begin
        a_v           = flush_v;
        pclass_next   = c_lts_pkg::P_NONE;
        pend_len_next = '0;
        prefix_next   = '0;
        b_v           = 1'b1;
        priority case (1'b1)
          c_lts_pkg::is_blank(ch): b_v = 1'b0;
          (ch == 8'h0A): begin
            b_v = 1'b0;
            if (line_count < c_lts_pkg::LINE_MAX) line_count_next = line_count + 21'd1;
            line_start_next = byte_index + IB'(1);
          end
          (ch == "+"): b_tok.kind = c_lts_pkg::KIND_PLUS;
          (ch == "-"): b_tok.kind = c_lts_pkg::KIND_MINUS;
          (ch == "*"): b_tok.kind = c_lts_pkg::KIND_STAR;
          (ch == "/"): b_tok.kind = c_lts_pkg::KIND_SLASH;
          (ch == "("): b_tok.kind = c_lts_pkg::KIND_LPAREN;
          (ch == ")"): b_tok.kind = c_lts_pkg::KIND_RPAREN;
          (ch == "{"): b_tok.kind = c_lts_pkg::KIND_LBRACE;
          (ch == "}"): b_tok.kind = c_lts_pkg::KIND_RBRACE;
          (ch == ","): b_tok.kind = c_lts_pkg::KIND_COMMA;
          (ch == ";"): b_tok.kind = c_lts_pkg::KIND_SEMI;
          (ch == "=") || (ch == "!") || (ch == ">") || (ch == "<") ||
          c_lts_pkg::is_digit(ch) || c_lts_pkg::is_letter(ch): begin
            b_v             = 1'b0;
            pend_start_next = byte_index;
            pend_len_next   = LB'(1);
            prefix_next     = {40'd0, ch};
            pend_line_next  = line_count;
            pend_col_next   = cur_col;
            if (ch == "=") pclass_next = c_lts_pkg::P_EQ;
            else if (ch == "!") pclass_next = c_lts_pkg::P_BANG;
            else if (ch == ">") pclass_next = c_lts_pkg::P_GT;
            else if (ch == "<") pclass_next = c_lts_pkg::P_LT;
            else if (c_lts_pkg::is_digit(ch)) pclass_next = c_lts_pkg::P_NUM;
            else pclass_next = c_lts_pkg::P_IDENT;
          end
          default: b_tok.kind = c_lts_pkg::KIND_ERROR;
        endcase
      end
    end
  end

  assign push               = accept && (a_v || b_v);
  assign push_entry.tok0    = a_v ? a_tok : b_tok;
  assign push_entry.tok1    = b_tok;
  assign push_entry.has_two = a_v && b_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      pclass     <= c_lts_pkg::P_NONE;
      pend_start <= '0;
      pend_len   <= '0;
      prefix     <= '0;
      byte_index <= '0;
      line_count <= 21'd1;
      line_start <= '0;
      pend_line  <= '0;
      pend_col   <= '0;
    end else if (accept) begin
      pclass     <= pclass_next;
      pend_start <= pend_start_next;
      pend_len   <= pend_len_next;
      prefix     <= prefix_next;
      byte_index <= byte_index_next;
      line_count <= line_count_next;
      line_start <= line_start_next;
      pend_line  <= pend_line_next;
      pend_col   <= pend_col_next;
    end
  end

endmodule
`default_nettype wire

>>> design/c_lts_fifo.sv
// short queue of token pairs between front and back
`default_nettype none
module c_lts_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire c_lts_pkg::entry_t push_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   q_valid,
  output c_lts_pkg::entry_t      q_entry
);

  localparam int PB = c_lts_pkg::FIFO_PTR_BITS;

  c_lts_pkg::entry_t mem [c_lts_pkg::FIFO_DEPTH];
  logic [PB-1:0] wptr, rptr;
  logic [PB:0]   count;

  assign full    = (count == (PB+1)'(c_lts_pkg::FIFO_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PB'(1);
      if (pop) rptr <= rptr + PB'(1);
      if (push && !pop) count <= count + (PB+1)'(1);
      else if (!push && pop) count <= count - (PB+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !q_valid))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> design/c_lts_back.sv
// back end: splits token pairs into single output items behind an output register
`default_nettype none
module c_lts_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire c_lts_pkg::entry_t q_entry,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output c_lts_pkg::token_t      out_tok,
  output logic                   out_last
);

  c_lts_pkg::token_t sec_tok;
  logic sec_valid;
  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = load && !sec_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (load) begin
      if (sec_valid) begin
        out_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else begin
        out_valid <= q_valid;
        sec_valid <= q_valid && q_entry.has_two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid) begin
        out_tok  <= sec_tok;
        out_last <= 1'b1;
      end else begin
        out_tok  <= q_entry.tok0;
        out_last <= !q_entry.has_two;
        sec_tok  <= q_entry.tok1;
      end
    end
  end

  a_second_behind_first: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> out_valid)
    else $error("second token held without a first");
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_last))
    else $error("second token of a pair not presented next");

endmodule
`default_nettype wire

>>> design/c_like_token_scanner_unit.sv
// top level of the streaming token scanner
//
//  channel   dir  fields
//  s_axis    in   tdata[7:0] ch, tuser end_of_text
//  m_axis    out  tdata kind,start,length,line,column; tlast last_of_run
//
// one byte item is taken per cycle while the queue has room
// a byte that yields two tokens is presented as two output items at the back end
// queue of four token pairs decouples input from output stalls
// first token of an item is registered in the queue and then in the output register
// synchronous reset: line 1, index 0, nothing pending, queue empty
`default_nettype none
module c_like_token_scanner_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // ch
  input  wire logic        s_axis_tuser,  // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // kind, start, length, line, column, zero pad
  output logic             m_axis_tlast
);

  logic              push, pop, full, q_valid;
  c_lts_pkg::entry_t push_entry, q_entry;
  c_lts_pkg::token_t out_tok;

  c_lts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .ch         (s_axis_tdata),
    .end_of_text(s_axis_tuser),
    .q_full     (full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  c_lts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (full),
    .q_valid   (q_valid),
    .q_entry   (q_entry)
  );

  c_lts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_tok  (out_tok),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_tok};

endmodule
`default_nettype wire
